### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that cons holds in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/alr_pkg.sv
// ---------------------------------------------------------------------------
// Antialiased line rasterizer package
// Fixed-point formats, widths, operation codes and the rounding helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alr_pkg;

    // Coordinate and slope formats
    localparam int COORD_INT_BITS  = 11;
    localparam int COORD_FRAC_BITS = 4;
    localparam int SLOPE_FRAC_BITS = 16;

    localparam int CW      = COORD_INT_BITS + COORD_FRAC_BITS; // endpoint width
    localparam int COL_W   = COORD_INT_BITS + 1;               // rounded column
    localparam int PIX_W   = 12;                               // pixel x / y
    localparam int IW      = 8;                                // intensity
    localparam int SLOPE_W = SLOPE_FRAC_BITS + 2;              // signed slope
    localparam int Y_W     = 30;                               // signed crossing
    localparam int GAP_W   = COORD_FRAC_BITS + 2;              // x gap, CF+1 frac
    localparam int DIFF_W  = COORD_FRAC_BITS + 2;              // signed round offset
    localparam int COV_W   = SLOPE_FRAC_BITS + 1;              // coverage, 0..1.0
    localparam int Q_W     = SLOPE_FRAC_BITS + 1;              // slope magnitude

    // Shared multiplier operand widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 9;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Right shift that turns coverage * gap * peak into an intensity
    localparam int INT_SHIFT = SLOPE_FRAC_BITS + COORD_FRAC_BITS + 1;

    localparam logic [SLOPE_W-1:0] SLOPE_ONE  = SLOPE_W'(2 ** SLOPE_FRAC_BITS);
    localparam logic [COV_W-1:0]   COV_ONE    = COV_W'(2 ** SLOPE_FRAC_BITS);
    localparam logic [GAP_W-1:0]   GAP_FULL   = GAP_W'(2 ** (COORD_FRAC_BITS + 1));
    localparam logic [CW:0]        ROUND_HALF = (CW + 1)'((2 ** COORD_FRAC_BITS) / 2);
    localparam logic [IW-1:0]      PEAK_RESET = IW'(255);

    // Input item operation codes
    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } op_t;

    // Round a fixed-point coordinate to the nearest integer (half rounds up)
    function automatic logic [COL_W-1:0] round_coord(input logic [CW-1:0] c);
        logic [CW:0] s;
        s = {1'b0, c} + ROUND_HALF;
        return s[CW:COORD_FRAC_BITS];
    endfunction

endpackage

`default_nettype wire

### rtl/alr_mul.sv
// ---------------------------------------------------------------------------
// Shared multiplier
// Signed multiplier with a registered product and a load enable.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alr_mul
    import alr_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       mul_en,
    input  wire logic signed [MUL_A_W-1:0]  mul_a,
    input  wire logic signed [MUL_B_W-1:0]  mul_b,
    output logic signed [MUL_P_W-1:0]       mul_p
);

    logic signed [MUL_P_W-1:0] prod_reg;

    // Capture a new product; hold it otherwise
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign mul_p = prod_reg;

endmodule

`default_nettype wire

### rtl/alr_div.sv
// ---------------------------------------------------------------------------
// Slope divider
// Restoring divider, one quotient bit per cycle: (dividend << SF) / divisor.
// The dividend must not exceed the divisor, so the quotient fits in SF+1 bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alr_div
    import alr_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             div_start,
    input  wire logic [CW-1:0]    div_dividend,
    input  wire logic [CW-1:0]    div_divisor,
    output logic                  div_done,
    output logic [Q_W-1:0]        div_quotient
);

    localparam int NUM_W = CW + SLOPE_FRAC_BITS;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [NUM_W-1:0] num;
    logic [CW-1:0]    rem_reg;
    logic [Q_W-1:0]   shift_reg;
    logic [Q_W-1:0]   quot_reg;
    logic [CW-1:0]    divisor_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CW:0]      partial;
    logic [CW:0]      trial;
    logic             fits;

    // Scaled dividend; the high part seeds the remainder
    assign num = {div_dividend, {SLOPE_FRAC_BITS{1'b0}}};

    // Shift in the next dividend bit and try the subtraction
    assign partial = {rem_reg, shift_reg[Q_W-1]};
    assign trial   = partial - {1'b0, divisor_reg};
    assign fits    = !trial[CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_start) begin
                busy_reg    <= 1'b1;
                cnt_reg     <= CNT_W'(Q_W);
                rem_reg     <= CW'(num[NUM_W-1:Q_W]);
                shift_reg   <= num[Q_W-1:0];
                divisor_reg <= div_divisor;
            end else if (busy_reg) begin
                rem_reg   <= fits ? trial[CW-1:0] : partial[CW-1:0];
                shift_reg <= {shift_reg[Q_W-2:0], 1'b0};
                quot_reg  <= {quot_reg[Q_W-2:0], fits};
                cnt_reg   <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign div_done     = done_reg;
    assign div_quotient = quot_reg;

endmodule

`default_nettype wire

### rtl/antialiased_line_rasterizer.sv
// ---------------------------------------------------------------------------
// Antialiased line rasterizer
// Wu-style line drawing on fixed-point endpoints, one pixel per output word.
// ---------------------------------------------------------------------------
// A start word (tuser = 0) carries two endpoints with 4 fraction bits. The
// block swaps axes for steep lines, orders the endpoints, divides once for
// the slope and then sends the four weighted pixels of the two end columns.
// Each step word (tuser = 1) sends the two pixels of the next interior
// column; a step with no open segment sends nothing. The final pixel of a
// segment has tlast set. Equal endpoints give one pixel at peak intensity.
// One small sequencer drives a shared registered multiplier through the
// COV, PEAK and EMIT states for each pixel, and a one-bit-per-cycle divider
// of 17 iterations. s_tready is high only between words, so a new word waits
// until every pixel of the last one is in the output register. The user must
// write peak_intensity through cfg_valid / cfg_data while idle; not enforced.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module antialiased_line_rasterizer
    import alr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Configuration write: peak_intensity
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,

    // Input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // x_start, y_start, x_end, y_end
    input  wire logic [0:0]  s_tuser,   // operation

    // Pixel words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pixel_x, pixel_y, intensity
    output logic             m_tlast    // last
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWAP,
        S_ORDER,
        S_SLOPE,
        S_DIV,
        S_YEND,
        S_YADD,
        S_COV,
        S_PEAK,
        S_EMIT
    } state_t;

    state_t               state_reg;
    logic                 steep_reg;
    logic                 active_reg;
    logic                 step_mode_reg;
    logic                 zero_reg;
    logic [1:0]           pix_reg;
    logic [COL_W-1:0]     cur_col_reg;
    logic [COL_W-1:0]     final_col_reg;
    logic [Y_W-1:0]       crossing_reg;
    logic [Y_W-1:0]       yend_reg;
    logic [SLOPE_W-1:0]   slope_reg;
    logic [IW-1:0]        peak_reg;
    logic [CW-1:0]        xa_reg;
    logic [CW-1:0]        ya_reg;
    logic [CW-1:0]        xb_reg;
    logic [CW-1:0]        yb_reg;

    logic                 m_tvalid_reg;
    logic [PIX_W-1:0]     m_px_reg;
    logic [PIX_W-1:0]     m_py_reg;
    logic [IW-1:0]        m_int_reg;
    logic                 m_last_reg;

    // Setup
    logic [CW-1:0]        adx;
    logic [CW-1:0]        ady;
    logic                 steep_c;
    logic [CW-1:0]        dx_c;
    logic                 dy_neg_c;
    logic [CW-1:0]        dy_mag_c;
    logic [COL_W-1:0]     xr_a;
    logic [COL_W-1:0]     xr_b;
    logic                 interior_c;

    // Divider
    logic                 div_start;
    logic                 div_done;
    logic [Q_W-1:0]       div_quotient;
    logic [SLOPE_W-1:0]   quot_ext;

    // End column
    logic                 end_sel;
    logic [CW-1:0]        x_sel;
    logic [CW-1:0]        y_sel;
    logic [COL_W-1:0]     xr_sel;
    logic [CW:0]          diff_full;
    logic [DIFF_W-1:0]    diff_sel;
    logic [GAP_W-2:0]     frac_odd;
    logic [GAP_W-1:0]     gap_sel;
    logic [COV_W-1:0]     cov_sel;
    logic [Y_W-1:0]       y_scaled;
    logic [Y_W-1:0]       slope_ext;
    logic [Y_W-1:0]       yend_next;

    // Multiplier
    logic                        mul_en;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [MUL_P_W-1:0]   mul_p;
    logic signed [MUL_P_W-1:0]   mul_p_shr;

    // Pixel
    logic                 emit_load;
    logic [PIX_W-1:0]     col_out;
    logic [PIX_W-1:0]     row_out;
    logic [IW-1:0]        int_out;
    logic                 last_out;
    logic                 step_last;

    // ---------------------------------------------------------------------
    // Setup arithmetic on the endpoint registers
    // ---------------------------------------------------------------------
    assign adx     = (xa_reg > xb_reg) ? (xa_reg - xb_reg) : (xb_reg - xa_reg);
    assign ady     = (ya_reg > yb_reg) ? (ya_reg - yb_reg) : (yb_reg - ya_reg);
    assign steep_c = ady > adx;

    assign dx_c       = xb_reg - xa_reg;
    assign dy_neg_c   = yb_reg < ya_reg;
    assign dy_mag_c   = dy_neg_c ? (ya_reg - yb_reg) : (yb_reg - ya_reg);
    assign xr_a       = round_coord(xa_reg);
    assign xr_b       = round_coord(xb_reg);
    assign interior_c = xr_b > (xr_a + COL_W'(1));

    assign div_start = (state_reg == S_SLOPE) && (dx_c != '0);
    assign quot_ext  = SLOPE_W'(div_quotient);

    alr_div u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .div_start    (div_start),
        .div_dividend (dy_mag_c),
        .div_divisor  (dx_c),
        .div_done     (div_done),
        .div_quotient (div_quotient)
    );

    // ---------------------------------------------------------------------
    // End column terms: rounded column, rounding offset, x gap, coverage
    // ---------------------------------------------------------------------
    assign end_sel   = pix_reg[1];
    assign x_sel     = end_sel ? xb_reg : xa_reg;
    assign y_sel     = end_sel ? yb_reg : ya_reg;
    assign xr_sel    = round_coord(x_sel);
    assign diff_full = {xr_sel, {COORD_FRAC_BITS{1'b0}}} - {1'b0, x_sel};
    assign diff_sel  = diff_full[DIFF_W-1:0];
    assign frac_odd  = {x_sel[COORD_FRAC_BITS-1:0], 1'b1};

    always_comb begin
        priority if (step_mode_reg) begin
            gap_sel = GAP_FULL;
        end else if (end_sel) begin
            gap_sel = {1'b0, frac_odd};
        end else begin
            gap_sel = GAP_FULL - {1'b0, frac_odd};
        end
    end

    // Lower pixel gets 1 - frac, upper pixel gets frac
    assign cov_sel = pix_reg[0] ? {1'b0, yend_reg[SLOPE_FRAC_BITS-1:0]}
                                : COV_ONE - {1'b0, yend_reg[SLOPE_FRAC_BITS-1:0]};

    // Endpoint y: y scaled to the slope format plus floored slope * offset
    assign mul_p_shr = mul_p >>> COORD_FRAC_BITS;
    assign y_scaled  = Y_W'({y_sel, {(SLOPE_FRAC_BITS - COORD_FRAC_BITS){1'b0}}});
    assign slope_ext = {{(Y_W - SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg};
    assign yend_next = y_scaled + mul_p_shr[Y_W-1:0];

    // ---------------------------------------------------------------------
    // Shared multiplier operands per sequencer step
    // ---------------------------------------------------------------------
    always_comb begin
        mul_en = 1'b1;
        unique case (state_reg)
            S_YEND: begin
                mul_a = {{(MUL_A_W - SLOPE_W){slope_reg[SLOPE_W-1]}}, slope_reg};
                mul_b = {{(MUL_B_W - DIFF_W){diff_sel[DIFF_W-1]}}, diff_sel};
            end
            S_COV: begin
                mul_a = {{(MUL_A_W - COV_W){1'b0}}, cov_sel};
                mul_b = {{(MUL_B_W - GAP_W){1'b0}}, gap_sel};
            end
            S_PEAK: begin
                mul_a = mul_p[MUL_A_W-1:0];
                mul_b = {{(MUL_B_W - IW){1'b0}}, peak_reg};
            end
            default: begin
                mul_en = 1'b0;
                mul_a  = '0;
                mul_b  = '0;
            end
        endcase
    end

    alr_mul u_mul (
        .aclk   (aclk),
        .mul_en (mul_en),
        .mul_a  (mul_a),
        .mul_b  (mul_b),
        .mul_p  (mul_p)
    );

    // ---------------------------------------------------------------------
    // Pixel word assembly
    // ---------------------------------------------------------------------
    assign emit_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);
    assign step_last = pix_reg[0] && ((cur_col_reg + COL_W'(1)) == final_col_reg);

    always_comb begin
        priority if (zero_reg) begin
            col_out  = PIX_W'(round_coord(xa_reg));
            row_out  = PIX_W'(round_coord(ya_reg));
            int_out  = peak_reg;
            last_out = 1'b1;
        end else if (step_mode_reg) begin
            col_out  = PIX_W'(cur_col_reg);
            row_out  = yend_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS]
                     + PIX_W'(pix_reg[0]);
            int_out  = mul_p[INT_SHIFT+IW-1:INT_SHIFT];
            last_out = step_last;
        end else begin
            col_out  = PIX_W'(xr_sel);
            row_out  = yend_reg[SLOPE_FRAC_BITS+PIX_W-1:SLOPE_FRAC_BITS]
                     + PIX_W'(pix_reg[0]);
            int_out  = mul_p[INT_SHIFT+IW-1:INT_SHIFT];
            last_out = (pix_reg == 2'd3) && !active_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer, segment state and output register
    // ---------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            steep_reg     <= 1'b0;
            active_reg    <= 1'b0;
            step_mode_reg <= 1'b0;
            zero_reg      <= 1'b0;
            pix_reg       <= '0;
            cur_col_reg   <= '0;
            final_col_reg <= '0;
            crossing_reg  <= '0;
            slope_reg     <= '0;
            peak_reg      <= PEAK_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                peak_reg <= cfg_data;
            end

            // Drop the word once taken, load a new one when the slot is free
            if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
                m_px_reg     <= steep_reg ? row_out : col_out;
                m_py_reg     <= steep_reg ? col_out : row_out;
                m_int_reg    <= int_out;
                m_last_reg   <= last_out;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser[0] == OP_STEP) begin
                            if (active_reg) begin
                                yend_reg      <= crossing_reg;
                                step_mode_reg <= 1'b1;
                                zero_reg      <= 1'b0;
                                pix_reg       <= '0;
                                state_reg     <= S_COV;
                            end
                        end else begin
                            xa_reg        <= s_tdata[CW-1:0];
                            ya_reg        <= s_tdata[2*CW-1:CW];
                            xb_reg        <= s_tdata[3*CW-1:2*CW];
                            yb_reg        <= s_tdata[4*CW-1:3*CW];
                            step_mode_reg <= 1'b0;
                            zero_reg      <= 1'b0;
                            pix_reg       <= '0;
                            state_reg     <= S_SWAP;
                        end
                    end
                end
                S_SWAP: begin
                    if ((xa_reg == xb_reg) && (ya_reg == yb_reg)) begin
                        zero_reg   <= 1'b1;
                        steep_reg  <= 1'b0;
                        active_reg <= 1'b0;
                        state_reg  <= S_EMIT;
                    end else begin
                        steep_reg <= steep_c;
                        if (steep_c) begin
                            xa_reg <= ya_reg;
                            ya_reg <= xa_reg;
                            xb_reg <= yb_reg;
                            yb_reg <= xb_reg;
                        end
                        state_reg <= S_ORDER;
                    end
                end
                S_ORDER: begin
                    // Run along the major axis in increasing order
                    if (xa_reg > xb_reg) begin
                        xa_reg <= xb_reg;
                        ya_reg <= yb_reg;
                        xb_reg <= xa_reg;
                        yb_reg <= ya_reg;
                    end
                    state_reg <= S_SLOPE;
                end
                S_SLOPE: begin
                    active_reg    <= interior_c;
                    cur_col_reg   <= xr_a + COL_W'(1);
                    final_col_reg <= xr_b;
                    if (dx_c == '0) begin
                        slope_reg <= SLOPE_ONE;
                        state_reg <= S_YEND;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        slope_reg <= dy_neg_c ? (SLOPE_W'(0) - quot_ext) : quot_ext;
                        state_reg <= S_YEND;
                    end
                end
                S_YEND: begin
                    state_reg <= S_YADD;
                end
                S_YADD: begin
                    yend_reg <= yend_next;
                    // First interior crossing follows the first end column
                    if (!end_sel) begin
                        crossing_reg <= yend_next + slope_ext;
                    end
                    state_reg <= S_COV;
                end
                S_COV: begin
                    state_reg <= S_PEAK;
                end
                S_PEAK: begin
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_load) begin
                        priority if (zero_reg) begin
                            state_reg <= S_IDLE;
                        end else if (step_mode_reg) begin
                            if (!pix_reg[0]) begin
                                pix_reg   <= 2'd1;
                                state_reg <= S_COV;
                            end else begin
                                // Advance to the next column
                                cur_col_reg  <= cur_col_reg + COL_W'(1);
                                crossing_reg <= crossing_reg + slope_ext;
                                if (step_last) begin
                                    active_reg <= 1'b0;
                                end
                                state_reg <= S_IDLE;
                            end
                        end else begin
                            pix_reg <= pix_reg + 2'd1;
                            priority if (pix_reg == 2'd3) begin
                                state_reg <= S_IDLE;
                            end else if (pix_reg == 2'd1) begin
                                state_reg <= S_YEND;
                            end else begin
                                state_reg <= S_COV;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_int_reg, m_py_reg, m_px_reg};
    assign m_tlast   = m_last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_IMPLIES(a_div_done_in_div, aclk, aresetn, div_done, state_reg == S_DIV)
    `ASSERT_NEXT(a_idle_step_no_output, aclk, aresetn, s_tvalid && s_tready && (s_tuser[0] == OP_STEP) && !active_reg, (state_reg == S_IDLE) && !(emit_load))
    `ASSERT_NEXT(a_last_closes_segment, aclk, aresetn, emit_load && last_out, !active_reg)
    `ASSERT_IMPLIES(a_step_two_pixels, aclk, aresetn, step_mode_reg && (state_reg != S_IDLE), pix_reg[1] == 1'b0)

endmodule

`default_nettype wire
